FILE: design/multi_waveform_lfo_top_defines.svh
// assertion macros for the multi-waveform lfo
// used by multi_waveform_lfo_top; no other dependencies
`ifndef MULTI_WAVEFORM_LFO_TOP_DEFINES_SVH
`define MULTI_WAVEFORM_LFO_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// check on every clock edge outside reset
`define MWLFO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
// check on every clock edge, reset included
`define MWLFO_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed");
`else
`define MWLFO_ASSERT(lbl, prop)
`define MWLFO_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: design/mwlfo_pkg.sv
// package for the multi-waveform lfo: widths, codes and the sine quarter rom
// no dependencies; imported by multi_waveform_lfo_top
`timescale 1ns / 1ps
`default_nettype none

package mwlfo_pkg;

  // phase fraction and sine table size
  localparam int PHASE_BITS      = 24;
  localparam int SINE_TABLE_BITS = 8;
  localparam int SINE_N          = 1 << SINE_TABLE_BITS;

  // field and register widths
  localparam int DT_W       = 16;
  localparam int RATE_W     = 24;
  localparam int GAIN_W     = 16;
  localparam int OUT_W      = 16;
  localparam int LFSR_W     = 16;
  localparam int SINE_W     = 15;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  // phase increment arithmetic
  localparam int PROD_W = DT_W + RATE_W;
  localparam int INC_W  = PROD_W - (32 - PHASE_BITS);

  // constants
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [SINE_W-1:0] SINE_PEAK = 15'h7FFF;
  localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0]       TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                   64'd110, 64'd156, 64'd210};

  // reset values of the registers
  localparam logic              RST_OSC_ENABLE   = 1'b1;
  localparam logic [RATE_W-1:0] RST_RATE_HZ      = 24'h010000;
  localparam logic [GAIN_W-1:0] RST_DEPTH_GAIN   = 16'h8000;
  localparam logic [OUT_W-1:0]  RST_LEVEL_OFFSET = 16'h0000;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_OSC_ENABLE   = 3'd0,
    CFG_WAVE_SELECT  = 3'd1,
    CFG_RATE_HZ      = 3'd2,
    CFG_DEPTH_GAIN   = 3'd3,
    CFG_LEVEL_OFFSET = 3'd4
  } cfg_reg_e;

  // waveform codes
  typedef enum logic [2:0] {
    WAVE_SINE     = 3'd0,
    WAVE_TRIANGLE = 3'd1,
    WAVE_SAW_UP   = 3'd2,
    WAVE_SAW_DOWN = 3'd3,
    WAVE_SQUARE   = 3'd4,
    WAVE_RANDOM   = 3'd5
  } wave_e;

  // request kinds
  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_SYNC = 1'b1
  } cmd_e;

  typedef logic [SINE_W-1:0] sine_rom_t [SINE_N];

  // quarter sine, round(32768*sin(pi/2*i/N)) capped, by an integer taylor series in q2.30
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] q;
    for (int i = 0; i < SINE_N; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int k = 0; k < 7; k++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[k];
        if (k[0] == 1'b0) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      q = (sum + 64'd16384) >> 15;
      rom[i] = (q > 64'(SINE_PEAK)) ? SINE_PEAK : q[SINE_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

FILE: design/multi_waveform_lfo_top.sv
// Multi-waveform lfo: tick-driven phase accumulator with six waveforms.
// A request enters the input register, then the result register once the output is free.
// Throughput: one request per cycle unless m_axis stalls; the input register and result register
// each hold one request, and one pass of waveform, scale and phase add sits between.
// Reset: phase and random hold clear, lfsr loads its seed, registers take their
// documented reset values, both pipeline registers empty.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_waveform_lfo_top_defines.svh"

module multi_waveform_lfo_top
  import mwlfo_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // request stream
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [DT_W-1:0]       s_axis_tdata_i,   // [15:0] delta_time
  input  wire logic                  s_axis_tuser_i,   // [0] command
  // result stream
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [OUT_W-1:0]           m_axis_tdata_o    // [15:0] mod_value
);

  // configuration registers
  logic              osc_enable_q;
  logic [2:0]        wave_sel_q;
  logic [RATE_W-1:0] rate_hz_q;
  logic [GAIN_W-1:0] depth_gain_q;
  logic [OUT_W-1:0]  level_offset_q;

  // oscillator state
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [LFSR_W-1:0]     lfsr_q, lfsr_d;
  logic [LFSR_W-1:0]     hold_q, hold_d;

  // pipeline registers
  logic            v1_q, v2_q;
  cmd_e            cmd1_q;
  logic [DT_W-1:0] dt1_q;
  logic [OUT_W-1:0] out_q, out_d;

  logic fire_in;
  logic fire2;
  logic lfsr_step;

  // handshake
  assign fire2           = v1_q && (!v2_q || m_axis_tready_i);
  assign s_axis_tready_o = !v1_q || fire2;
  assign fire_in         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = v2_q;
  assign m_axis_tdata_o  = out_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      osc_enable_q   <= RST_OSC_ENABLE;
      wave_sel_q     <= WAVE_SINE;
      rate_hz_q      <= RST_RATE_HZ;
      depth_gain_q   <= RST_DEPTH_GAIN;
      level_offset_q <= RST_LEVEL_OFFSET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_OSC_ENABLE:   osc_enable_q   <= cfg_wdata_i[0];
        CFG_WAVE_SELECT:  wave_sel_q     <= cfg_wdata_i[2:0];
        CFG_RATE_HZ:      rate_hz_q      <= cfg_wdata_i[RATE_W-1:0];
        CFG_DEPTH_GAIN:   depth_gain_q   <= cfg_wdata_i[GAIN_W-1:0];
        CFG_LEVEL_OFFSET: level_offset_q <= cfg_wdata_i[OUT_W-1:0];
        default: ;
      endcase
    end
  end

  // top 16 phase bits and sine addressing
  logic [15:0]                f;
  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-1:0] sidx, ridx;
  logic [SINE_W-1:0]          srom;
  logic signed [16:0]         sine_mag;

  assign f    = phase_q[PHASE_BITS-1 -: 16];
  assign quad = phase_q[PHASE_BITS-1 -: 2];
  assign sidx = phase_q[PHASE_BITS-3 -: SINE_TABLE_BITS];
  assign ridx = quad[0] ? (SINE_TABLE_BITS'(0) - sidx) : sidx;
  assign srom = SINE_ROM[ridx];

  // mirrored quadrants read the peak at their first entry
  always_comb begin
    if (quad[0] && (sidx == '0)) begin
      sine_mag = $signed({2'b00, SINE_PEAK});
    end else begin
      sine_mag = $signed({2'b00, srom});
    end
  end

  // waveform select
  logic signed [16:0] wave;
  logic signed [17:0] tri_up, tri_dn;

  assign tri_up = $signed({1'b0, f, 1'b0}) - 18'sd32768;
  assign tri_dn = 18'sd98304 - $signed({1'b0, f, 1'b0});

  always_comb begin
    unique case (wave_sel_q)
      WAVE_SINE:     wave = quad[1] ? -sine_mag : sine_mag;
      WAVE_TRIANGLE: wave = f[15] ? tri_dn[16:0] : tri_up[16:0];
      WAVE_SAW_UP:   wave = $signed({1'b0, f}) - 17'sd32768;
      WAVE_SAW_DOWN: wave = 17'sd32768 - $signed({1'b0, f});
      WAVE_SQUARE:   wave = f[15] ? -17'sd32768 : 17'sd32768;
      WAVE_RANDOM:   wave = $signed({hold_q[LFSR_W-1], hold_q});
      default:       wave = '0;
    endcase
  end

  // scale by gain with rounding, add offset, saturate
  logic signed [33:0] scaled_prod;
  logic signed [34:0] scaled_rnd;
  logic signed [19:0] level_sum;
  logic [OUT_W-1:0]   level_sat;

  assign scaled_prod = wave * $signed({1'b0, depth_gain_q});
  assign scaled_rnd  = 35'(scaled_prod) + 35'sd16384;
  assign level_sum   = 20'(scaled_rnd[34:15])
                     + 20'($signed(level_offset_q));

  always_comb begin
    if (level_sum > 20'sd32767) begin
      level_sat = 16'h7FFF;
    end else if (level_sum < -20'sd32768) begin
      level_sat = 16'h8000;
    end else begin
      level_sat = level_sum[OUT_W-1:0];
    end
  end

  // phase advance
  logic [PROD_W-1:0] ph_prod;
  logic [INC_W-1:0]  ph_inc;
  logic [INC_W:0]    ph_sum;
  logic              wrap;
  logic              lfsr_fb;

  assign ph_prod = dt1_q * rate_hz_q;
  assign ph_inc  = ph_prod[PROD_W-1 -: INC_W];
  assign ph_sum  = {{(INC_W + 1 - PHASE_BITS){1'b0}}, phase_q} + {1'b0, ph_inc};
  assign wrap    = |ph_sum[INC_W:PHASE_BITS];
  assign lfsr_fb = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];

  // result and next state for the request in the input register
  always_comb begin
    phase_d   = phase_q;
    lfsr_d    = lfsr_q;
    hold_d    = hold_q;
    out_d     = '0;
    lfsr_step = 1'b0;
    priority if (cmd1_q == CMD_SYNC) begin
      phase_d = '0;
    end else if (osc_enable_q) begin
      out_d     = level_sat;
      phase_d   = ph_sum[PHASE_BITS-1:0];
      lfsr_step = wrap && (wave_sel_q == WAVE_RANDOM);
      if (lfsr_step) begin
        lfsr_d = {lfsr_fb, lfsr_q[LFSR_W-1:1]};
        hold_d = {lfsr_fb, lfsr_q[LFSR_W-1:1]};
      end
    end else begin
      out_d = '0;
    end
  end

  // state and valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      lfsr_q  <= LFSR_SEED;
      hold_q  <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      if (fire2) begin
        phase_q <= phase_d;
        lfsr_q  <= lfsr_d;
        hold_q  <= hold_d;
      end
      if (fire_in) begin
        v1_q <= 1'b1;
      end else if (fire2) begin
        v1_q <= 1'b0;
      end
      if (fire2) begin
        v2_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        v2_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (fire_in) begin
      cmd1_q <= cmd_e'(s_axis_tuser_i);
      dt1_q  <= s_axis_tdata_i;
    end
    if (fire2) begin
      out_q <= out_d;
    end
  end

  // checks
  `MWLFO_ASSERT(a_sync_clears_phase, (fire2 && (cmd1_q == CMD_SYNC)) |=> (phase_q == '0))
  `MWLFO_ASSERT(a_lfsr_only_on_wrap, !(fire2 && lfsr_step) |=> $stable(lfsr_q))
  `MWLFO_ASSERT(a_stall_only_when_full, !s_axis_tready_o |-> (v1_q && v2_q))
  `MWLFO_ASSERT_ALWAYS(a_lfsr_nonzero, !rst_ni || (lfsr_q != '0))

endmodule

`default_nettype wire

FILE: tb/sv/tb_multi_waveform_lfo_top.sv
// self-checking testbench for multi_waveform_lfo_top: directed and random ticks and syncs
// across many register settings, checked against an in-bench oscillator model
// depends on mwlfo_pkg and the multi_waveform_lfo_top rtl only
`timescale 1ns / 1ps

module tb_multi_waveform_lfo_top
  import mwlfo_pkg::*;
();

  // codes that the package leaves unnamed: waveform reads zero
  localparam logic [2:0] WAVE_UNUSED_LO = 3'd6;
  localparam logic [2:0] WAVE_UNUSED_HI = 3'd7;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int MAX_REPORTS   = 10;
  localparam int SEGMENTS      = 14;
  localparam int SEGMENT_ITEMS = 125;

  // oscillator model and the queue of mod_value results still owed
  class lfo_scoreboard;
    logic [SINE_W-1:0]     quarter_sine [SINE_N];
    logic                  en_q;
    logic [2:0]            wave_q;
    logic [RATE_W-1:0]     rate_q;
    logic [GAIN_W-1:0]     gain_q;
    logic [OUT_W-1:0]      offset_q;
    logic [PHASE_BITS-1:0] phase_q;
    logic [LFSR_W-1:0]     hold_q;
    logic [LFSR_W-1:0]     lfsr_q;
    logic [OUT_W-1:0]      expected_mod [$];
    int n_errors, n_checked, n_requests, n_syncs, n_idle_ticks, n_hold_updates;

    function new();
      longint unsigned x, x2, term, acc, q;
      // quarter sine in q2.30 by an eight-term taylor series, rounded to q.15
      for (int i = 0; i < SINE_N; i++) begin
        x    = (64'd1686629713 * longint'(i)) / SINE_N;
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int k = 1; k <= 7; k++) begin
          term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
          if (k % 2 == 1) begin
            acc = acc - term;
          end else begin
            acc = acc + term;
          end
        end
        q = (acc + 64'd16384) >> 15;
        if (q > 64'd32767) q = 64'd32767;
        quarter_sine[i] = q[SINE_W-1:0];
      end
      en_q     = RST_OSC_ENABLE;
      wave_q   = WAVE_SINE;
      rate_q   = RST_RATE_HZ;
      gain_q   = RST_DEPTH_GAIN;
      offset_q = RST_LEVEL_OFFSET;
      phase_q  = '0;
      hold_q   = '0;
      lfsr_q   = LFSR_SEED;
    endfunction

    function void set_registers(logic en, logic [2:0] wv, logic [RATE_W-1:0] rt,
                                logic [GAIN_W-1:0] gn, logic [OUT_W-1:0] ofs);
      en_q     = en;
      wave_q   = wv;
      rate_q   = rt;
      gain_q   = gn;
      offset_q = ofs;
    endfunction

    function int sine_value();
      logic [1:0]                 quad;
      logic [SINE_TABLE_BITS-1:0] idx;
      logic [SINE_TABLE_BITS-1:0] mirror;
      int v;
      quad   = phase_q[PHASE_BITS-1 -: 2];
      idx    = phase_q[PHASE_BITS-3 -: SINE_TABLE_BITS];
      mirror = ~idx + 1'b1;
      // odd quadrants run the table backwards, peak at their first entry
      if (quad[0]) begin
        v = (idx == 0) ? 32767 : int'(quarter_sine[mirror]);
      end else begin
        v = int'(quarter_sine[idx]);
      end
      return quad[1] ? -v : v;
    endfunction

    function int wave_value();
      int f;
      f = int'(phase_q[PHASE_BITS-1 -: 16]);
      case (wave_q)
        WAVE_SINE:     return sine_value();
        WAVE_TRIANGLE: return (f < 32768) ? 2 * f - 32768 : 98304 - 2 * f;
        WAVE_SAW_UP:   return f - 32768;
        WAVE_SAW_DOWN: return 32768 - f;
        WAVE_SQUARE:   return (f < 32768) ? 32768 : -32768;
        WAVE_RANDOM:   return int'($signed(hold_q));
        default:       return 0;
      endcase
    endfunction

    // one request in, one mod_value out; state moves as the block's would
    function logic [OUT_W-1:0] predict_mod_value(cmd_e cmd, logic [DT_W-1:0] dt);
      longint                  y;
      logic [DT_W+RATE_W-1:0]  prod;
      logic [DT_W+RATE_W:0]    total;
      logic                    fb;
      if (cmd == CMD_SYNC) begin
        phase_q = '0;
        n_syncs++;
        return '0;
      end
      if (!en_q) begin
        n_idle_ticks++;
        return '0;
      end
      y = (longint'(wave_value()) * longint'(gain_q) + 64'sd16384) >>> 15;
      y = y + longint'($signed(offset_q));
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      // phase advance, wrap steps the noise source once in random mode
      prod  = dt * rate_q;
      total = phase_q + (prod >> (32 - PHASE_BITS));
      if ((total >> PHASE_BITS) != 0 && wave_q == WAVE_RANDOM) begin
        fb     = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
        lfsr_q = {fb, lfsr_q[LFSR_W-1:1]};
        hold_q = lfsr_q;
        n_hold_updates++;
      end
      phase_q = total[PHASE_BITS-1:0];
      return y[OUT_W-1:0];
    endfunction

    function void note_request(cmd_e cmd, logic [DT_W-1:0] dt);
      logic [OUT_W-1:0] want;
      n_requests++;
      want         = predict_mod_value(cmd, dt);
      expected_mod = {expected_mod, want};
    endfunction

    function void check_result(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (expected_mod.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("[%0t] unexpected result mod_value=%0d", $realtime, $signed(got));
        return;
      end
      want = expected_mod.pop_front();
      n_checked++;
      if (got !== want) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("[%0t] mod_value mismatch: expected %0d, got %0d", $realtime,
                   $signed(want), $signed(got));
      end
    endfunction

    function int pending();
      return expected_mod.size();
    endfunction
  endclass

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr    = CFG_OSC_ENABLE;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                  s_valid     = 1'b0;
  logic                  s_ready;
  logic [DT_W-1:0]       s_data      = '0;
  logic                  s_user      = CMD_TICK;
  logic                  m_valid;
  logic                  m_ready     = 1'b0;
  logic [OUT_W-1:0]      m_data;

  lfo_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_cnt = 0;
  int n_settings = 0;

  multi_waveform_lfo_top DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // [15:0] delta_time
    .s_axis_tuser_i  (s_user),   // [0] command
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)    // [15:0] mod_value
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // result side: check accepted results, stall at random
  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) sb.check_result(m_data);
    m_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one request, with random idle cycles ahead of it
  task automatic send_request(cmd_e cmd, logic [DT_W-1:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= dt;
    s_user  <= cmd;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    sb.note_request(cmd, dt);
  endtask

  // stop sending and wait until every owed result is back
  task automatic settle();
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_settings(logic en, logic [2:0] wv, logic [RATE_W-1:0] rt,
                                logic [GAIN_W-1:0] gn, logic [OUT_W-1:0] ofs);
    write_reg(CFG_OSC_ENABLE, CFG_DATA_W'(en));
    write_reg(CFG_WAVE_SELECT, CFG_DATA_W'(wv));
    write_reg(CFG_RATE_HZ, rt);
    write_reg(CFG_DEPTH_GAIN, CFG_DATA_W'(gn));
    write_reg(CFG_LEVEL_OFFSET, CFG_DATA_W'(ofs));
    cfg_we <= 1'b0;
    sb.set_registers(en, wv, rt, gn, ofs);
    n_settings++;
  endtask

  // random register setting, extremes weighted in
  task automatic random_settings();
    logic              en;
    logic [2:0]        wv;
    logic [RATE_W-1:0] rt;
    logic [GAIN_W-1:0] gn;
    logic [OUT_W-1:0]  ofs;
    en = ($urandom_range(9) != 0);
    if ($urandom_range(9) == 0) begin
      wv = 3'($urandom_range(WAVE_UNUSED_HI, WAVE_UNUSED_LO));
    end else begin
      wv = 3'($urandom_range(WAVE_RANDOM, WAVE_SINE));
    end
    case ($urandom_range(4))
      0:       rt = '1;
      1:       rt = RATE_W'($urandom_range(255));
      2:       rt = RATE_W'($urandom_range(262144));
      3:       rt = RATE_W'($urandom);
      default: rt = RST_RATE_HZ;
    endcase
    case ($urandom_range(4))
      0:       gn = '0;
      1:       gn = RST_DEPTH_GAIN;
      2:       gn = '1;
      3:       gn = GAIN_W'($urandom);
      default: gn = GAIN_W'($urandom_range(32768));
    endcase
    case ($urandom_range(4))
      0:       ofs = 16'h8000;
      1:       ofs = 16'h7FFF;
      2:       ofs = '0;
      3:       ofs = OUT_W'($urandom);
      default: ofs = OUT_W'($urandom_range(2000)) - 16'd1000;
    endcase
    apply_settings(en, wv, rt, gn, ofs);
  endtask

  function automatic logic [DT_W-1:0] random_delta();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? '1 : '0;
      1, 2, 3: return DT_W'($urandom_range(255));
      default: return DT_W'($urandom);
    endcase
  endfunction

  // run timeout
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("run timed out after %0d cycles, %0d results owed", cycle_cnt, sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

  // main sequence
  initial begin
    int n_fail;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: sine at 1 hz, unity gain, no offset
    send_request(CMD_TICK, 16'h0000);
    send_request(CMD_TICK, 16'hFFFF);
    send_request(CMD_SYNC, 16'h1234);
    settle();
    // top rate with several wraps per tick, gain above one, top offset
    apply_settings(1'b1, WAVE_SINE, 24'hFFFFFF, 16'hFFFF, 16'h7FFF);
    send_request(CMD_TICK, 16'h4000);
    send_request(CMD_TICK, 16'hFFFF);
    send_request(CMD_TICK, 16'h0001);
    settle();
    // random hold across wraps, held value shows one tick later
    apply_settings(1'b1, WAVE_RANDOM, 24'hFFFFFF, RST_DEPTH_GAIN, 16'h0000);
    send_request(CMD_TICK, 16'hFFFF);
    send_request(CMD_TICK, 16'hFFFF);
    send_request(CMD_TICK, 16'h0000);
    settle();
    // zero gain, bottom offset
    apply_settings(1'b1, WAVE_TRIANGLE, RST_RATE_HZ, 16'h0000, 16'h8000);
    send_request(CMD_TICK, 16'd5000);
    send_request(CMD_TICK, 16'd40000);
    settle();
    // zero rate holds the phase
    apply_settings(1'b1, WAVE_SAW_UP, 24'h000000, RST_DEPTH_GAIN, 16'h0000);
    send_request(CMD_TICK, 16'hFFFF);
    settle();
    apply_settings(1'b1, WAVE_SAW_DOWN, RST_RATE_HZ, RST_DEPTH_GAIN, 16'h0000);
    send_request(CMD_TICK, 16'h8000);
    send_request(CMD_TICK, 16'h8000);
    settle();
    apply_settings(1'b1, WAVE_SQUARE, RST_RATE_HZ, RST_DEPTH_GAIN, 16'h0000);
    send_request(CMD_TICK, 16'h8000);
    send_request(CMD_TICK, 16'h8000);
    settle();
    // unused wave codes give the offset alone
    apply_settings(1'b1, WAVE_UNUSED_LO, RST_RATE_HZ, RST_DEPTH_GAIN, 16'd1234);
    send_request(CMD_TICK, 16'd100);
    settle();
    apply_settings(1'b1, WAVE_UNUSED_HI, RST_RATE_HZ, RST_DEPTH_GAIN, 16'd1234);
    send_request(CMD_TICK, 16'd100);
    settle();
    // disabled: zero out, phase holds, sync still clears
    apply_settings(1'b0, WAVE_SINE, RST_RATE_HZ, RST_DEPTH_GAIN, 16'd1234);
    send_request(CMD_TICK, 16'd1000);
    send_request(CMD_SYNC, 16'd2000);
    settle();
    apply_settings(1'b1, WAVE_SINE, RST_RATE_HZ, RST_DEPTH_GAIN, RST_LEVEL_OFFSET);
    send_request(CMD_TICK, 16'h0000);
    settle();

    // random segments, each under its own setting and idle pattern
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      random_settings();
      case (seg % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        // sender holds off mid-segment until the pipe is empty
        if (n == SEGMENT_ITEMS / 2 && (seg == 2 || $urandom_range(3) == 0)) settle();
        send_request(($urandom_range(19) == 0) ? CMD_SYNC : CMD_TICK, random_delta());
      end
      settle();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    settle();
    repeat (8) @(posedge clk);
    n_fail = sb.n_errors + sb.pending();
    $display("run covered %0d requests (%0d syncs, %0d disabled ticks) under %0d settings",
             sb.n_requests, sb.n_syncs, sb.n_idle_ticks, n_settings);
    $display("%0d results checked, %0d random hold updates, %0d errors",
             sb.n_checked, sb.n_hold_updates, n_fail);
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: multi_waveform_lfo_top.f
+incdir+design
design/mwlfo_pkg.sv
design/multi_waveform_lfo_top.sv
tb/sv/tb_multi_waveform_lfo_top.sv
